@@ design/dwg_pkg.sv @@
// Shared types, widths and constants of the DAC waveform generator.
package dwg_pkg;

  // Fixed field widths
  localparam int TICK_W     = 32;
  localparam int CODE_W     = 8;
  localparam int STEP_W     = 32;
  localparam int AMP_CFG_W  = 12;
  localparam int ROM_W      = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Largest output code
  localparam logic [CODE_W-1:0] CODE_MAX = '1;

  // Fixed-point constants of the sine evaluation (Q30)
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SEL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 8'd2;

  typedef enum logic [1:0] {
    WAVE_SINE,
    WAVE_HARM,
    WAVE_TRI,
    WAVE_RAMP
  } wave_sel_e;

  typedef struct packed {
    wave_sel_e              sel;
    logic [AMP_CFG_W-1:0]   amp_level;
    logic [STEP_W-1:0]      step;
  } cfg_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

@@ design/dwg_phase.sv @@
// Phase pipeline: tick register, phase multiply, table index and linear wave value.
module dwg_phase #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dwg_pkg::cfg_t                       cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dwg_pkg::TICK_W-1:0]          tick_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [$clog2(SINE_TABLE_DEPTH)-1:0] idx_o,
  output logic [PHASE_BITS:0]                 wave_o
);
  import dwg_pkg::*;

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int DEP_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int MUL_W = PHASE_BITS + DEP_W;
  localparam logic [PHASE_BITS:0] FULL = {1'b1, {PHASE_BITS{1'b0}}};

  logic                  v1_q, v2_q, v3_q;
  logic                  en1, en2, en3;
  logic [TICK_W-1:0]     tick_q;
  logic [PHASE_BITS-1:0] phase_q;
  logic [IDX_W-1:0]      idx_q;
  logic [PHASE_BITS:0]   wave_q;
  logic [TICK_W-1:0]     prod;
  logic [MUL_W-1:0]      idx_prod;
  logic [PHASE_BITS:0]   dbl;
  logic [PHASE_BITS:0]   wave_d;

  // Stage enables: a stage loads when empty or when its successor moves
  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // Low word of tick times step is the phase in turns
  assign prod     = tick_q * cfg_i.step;
  assign idx_prod = MUL_W'(phase_q) * MUL_W'(SINE_TABLE_DEPTH);
  assign dbl      = {phase_q, 1'b0};

  // Triangle folds at half period, ramp falls from full scale
  always_comb begin
    case (cfg_i.sel)
      WAVE_TRI: begin
        if (!phase_q[PHASE_BITS-1]) wave_d = FULL - dbl;
        else                        wave_d = dbl - FULL;
      end
      default: wave_d = FULL - {1'b0, phase_q};
    endcase
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) tick_q <= tick_i;
    if (en2 && v1_q) phase_q <= prod[TICK_W-1 -: PHASE_BITS];
    if (en3 && v2_q) begin
      idx_q  <= idx_prod[PHASE_BITS +: IDX_W];
      wave_q <= wave_d;
    end
  end

  assign out_valid_o = v3_q;
  assign idx_o       = idx_q;
  assign wave_o      = wave_q;

endmodule

@@ design/dwg_wave.sv @@
// Waveform stage: sine and harmonic-sum tables read into a register, wave value select.
module dwg_wave #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dwg_pkg::cfg_t                       cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] idx_i,
  input  logic [PHASE_BITS:0]                 wave_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dwg_pkg::max_int(PHASE_BITS + 1, dwg_pkg::ROM_W)-1:0] val_o
);
  import dwg_pkg::*;

  localparam int VAL_W = max_int(PHASE_BITS + 1, ROM_W);

  typedef logic [ROM_W-1:0] rom_t [SINE_TABLE_DEPTH];

  // Sine of entry idx in signed Q30, quarter-wave folded Horner series
  function automatic longint sine_entry(input int unsigned idx);
    logic [63:0] u;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [1:0]  quad;
    u    = (64'(idx) << 32) / 64'(SINE_TABLE_DEPTH);
    quad = u[31:30];
    r    = {34'd0, u[29:0]};
    if (quad[0]) r = Q30_ONE - r;
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    t  = (x * t) >> 30;
    if (t > Q30_ONE) t = Q30_ONE;
    return quad[1] ? -longint'(t) : longint'(t);
  endfunction

  // Offset table: mid scale plus the sine, or plus the odd-harmonic sum
  function automatic rom_t build_rom(input logic harm);
    rom_t   rom;
    longint h;
    longint v;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      h = 0;
      if (harm) begin
        h = sine_entry(32'(i))
          + sine_entry(32'((i * 3) % SINE_TABLE_DEPTH)) / 3
          + sine_entry(32'((i * 5) % SINE_TABLE_DEPTH)) / 5
          + sine_entry(32'((i * 7) % SINE_TABLE_DEPTH)) / 7
          + sine_entry(32'((i * 9) % SINE_TABLE_DEPTH)) / 9;
      end else begin
        h = sine_entry(32'(i));
      end
      v = longint'(Q30_ONE) + h;
      if (v < 0) v = 0;
      if (v > 2 * longint'(Q30_ONE)) v = 2 * longint'(Q30_ONE);
      rom[i] = ROM_W'(v);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom(1'b0);
  localparam rom_t HARM_ROM = build_rom(1'b1);

  logic                v_q;
  logic                en;
  logic [ROM_W-1:0]    rom_q;
  logic [PHASE_BITS:0] wave_q;

  assign en         = !v_q || out_ready_i;
  assign in_ready_o = en;

  // Hold valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (en) v_q <= in_valid_i;
  end

  // Registered table read
  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      rom_q  <= (cfg_i.sel == WAVE_HARM) ? HARM_ROM[idx_i] : SINE_ROM[idx_i];
      wave_q <= wave_i;
    end
  end

  // Select the table value for the sine modes, the linear value otherwise
  always_comb begin
    case (cfg_i.sel)
      WAVE_SINE, WAVE_HARM: val_o = VAL_W'(rom_q);
      default:              val_o = VAL_W'(wave_q);
    endcase
  end

  assign out_valid_o = v_q;

endmodule

@@ design/dwg_scale.sv @@
// Scaling pipeline: amplitude multiply, times 255, divide by full-scale amplitude, saturate.
module dwg_scale #(
  parameter int PHASE_BITS = 32,
  parameter int AMP_BITS   = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dwg_pkg::cfg_t                       cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dwg_pkg::max_int(PHASE_BITS + 1, dwg_pkg::ROM_W)-1:0] val_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dwg_pkg::CODE_W-1:0]          code_o
);
  import dwg_pkg::*;

  localparam int VAL_W   = max_int(PHASE_BITS + 1, ROM_W);
  localparam int PROD_W  = AMP_BITS + VAL_W;
  localparam int T_W     = PROD_W + 8;
  localparam int MW      = AMP_BITS + 8;
  localparam int CMP_W   = max_int(AMP_BITS, AMP_CFG_W);
  localparam int AMP_MAX = (1 << AMP_BITS) - 1;
  localparam int RECIP   = (1 << MW) / AMP_MAX;
  localparam int RW      = 10;
  localparam int QW      = 9;
  localparam int TABLE_SHIFT = 31;

  logic              v5_q, v6_q, v7_q, v8_q;
  logic              en5, en6, en7, en8;
  logic [AMP_BITS-1:0] amp;
  logic [CMP_W-1:0]  lvl_ext;
  logic [PROD_W-1:0] p_q;
  logic [T_W-1:0]    t255;
  logic [MW-1:0]     m6_q, m7_q;
  logic [MW+RW-1:0]  qprod;
  logic [QW-1:0]     q0_q;
  logic [MW-1:0]     qd;
  logic [MW-1:0]     rem;
  logic [QW-1:0]     q;
  logic [CODE_W-1:0] code_q;

  // Clamp the amplitude at full scale
  assign lvl_ext = CMP_W'(cfg_i.amp_level);
  assign amp     = (lvl_ext > CMP_W'(AMP_MAX)) ? AMP_BITS'(AMP_MAX) : AMP_BITS'(lvl_ext);

  // Stage enables
  assign en8        = !v8_q || out_ready_i;
  assign en7        = !v7_q || en8;
  assign en6        = !v6_q || en7;
  assign en5        = !v5_q || en6;
  assign in_ready_o = en5;

  // Times 255, then drop the fraction of the wave value
  assign t255 = {p_q, 8'd0} - T_W'(p_q);

  // Reciprocal estimate is low by at most one
  assign qprod = (MW + RW)'(m6_q) * (MW + RW)'(RECIP);
  assign qd    = MW'(MW'(q0_q) * MW'(AMP_MAX));
  assign rem   = m7_q - qd;
  assign q     = (rem >= MW'(AMP_MAX)) ? q0_q + QW'(1) : q0_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      if (en5) v5_q <= in_valid_i;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
      if (en8) v8_q <= v7_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en5 && in_valid_i) p_q <= PROD_W'(amp) * PROD_W'(val_i);
    if (en6 && v5_q) begin
      case (cfg_i.sel)
        WAVE_SINE, WAVE_HARM: m6_q <= t255[TABLE_SHIFT +: MW];
        default:              m6_q <= t255[PHASE_BITS +: MW];
      endcase
    end
    if (en7 && v6_q) begin
      q0_q <= qprod[MW +: QW];
      m7_q <= m6_q;
    end
    if (en8 && v7_q) begin
      code_q <= (q > QW'(CODE_MAX)) ? CODE_MAX : q[CODE_W-1:0];
    end
  end

  assign out_valid_o = v8_q;
  assign code_o      = code_q;

endmodule

@@ design/dac_waveform_generator_top.sv @@
// Top level of the DAC waveform generator: configuration registers and pipeline.
//
// Each request on the slave stream carries a 32-bit timer tick count; the block
// returns one 8-bit DAC code per request on the master stream, in order.
// The phase is tick times phase_step modulo one turn; the code is an offset
// sine, a five-odd-harmonic square approximation, a triangle or a falling
// ramp, scaled by the amplitude register and saturated to 0..255.
// Configuration goes over its own write channel (index 0 waveform select,
// 1 amplitude, 2 phase step; other indexes are ignored) and is always ready.
// Throughput is one request per cycle while the receiver accepts, set by
// eight register stages that each advance when their successor moves; the
// phase multiply, the table read, the amplitude multiply and the reciprocal
// divide each own a stage, and m_axis_tvalid comes from the last one.
// The sine and harmonic tables are constant ROMs of SINE_TABLE_DEPTH entries
// with a registered read; they need no fill after reset.
// Reset empties the pipeline and clears the registers (sine, amplitude 0,
// phase step 0). When the receiver stalls, the stages fill up one by one and
// s_axis_tready falls only once every stage holds a request; nothing is lost.
module dac_waveform_generator_top #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int PHASE_BITS       = 32,
  parameter int AMP_BITS         = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dwg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dwg_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Tick stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [dwg_pkg::TICK_W-1:0]        s_axis_tdata,  // [31:0] tick_count
  // Code stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [dwg_pkg::CODE_W-1:0]        m_axis_tdata   // [7:0] dac_code
);
  import dwg_pkg::*;

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int VAL_W = max_int(PHASE_BITS + 1, ROM_W);

  cfg_t                cfg_q;
  logic                ph_valid, ph_ready;
  logic [IDX_W-1:0]    ph_idx;
  logic [PHASE_BITS:0] ph_wave;
  logic                wv_valid, wv_ready;
  logic [VAL_W-1:0]    wv_val;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sel       <= WAVE_SINE;
      cfg_q.amp_level <= '0;
      cfg_q.step      <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WAVE_SEL: cfg_q.sel       <= wave_sel_e'(cfg_data_i[1:0]);
        CFG_AMP:      cfg_q.amp_level <= cfg_data_i[AMP_CFG_W-1:0];
        CFG_STEP:     cfg_q.step      <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  dwg_phase #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .tick_i      (s_axis_tdata),
    .out_valid_o (ph_valid),
    .out_ready_i (ph_ready),
    .idx_o       (ph_idx),
    .wave_o      (ph_wave)
  );

  dwg_wave #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_wave (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (ph_valid),
    .in_ready_o  (ph_ready),
    .idx_i       (ph_idx),
    .wave_i      (ph_wave),
    .out_valid_o (wv_valid),
    .out_ready_i (wv_ready),
    .val_o       (wv_val)
  );

  dwg_scale #(
    .PHASE_BITS (PHASE_BITS),
    .AMP_BITS   (AMP_BITS)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (wv_valid),
    .in_ready_o  (wv_ready),
    .val_i       (wv_val),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .code_o      (m_axis_tdata)
  );

endmodule
